// ===== src/fpa_pkg.sv =====
// Shared types, constants and saturation helpers for the Q23.8 fixed-point ALU.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
package fpa_pkg;

   localparam int DATA_W       = 32;
   localparam int OP_W         = 4;
   localparam int FRAC_BITS_DF = 8;
   // One quotient bit per divider stage.
   localparam int DIV_STEPS    = DATA_W;
   // Accept edge to the edge at which the response is taken.
   localparam int LATENCY      = DIV_STEPS + 3;

   typedef enum logic [OP_W-1:0] {
      OP_ADD     = 4'd0,
      OP_SUB     = 4'd1,
      OP_MUL     = 4'd2,
      OP_DIV     = 4'd3,
      OP_MIN     = 4'd4,
      OP_MAX     = 4'd5,
      OP_INC     = 4'd6,
      OP_DEC     = 4'd7,
      OP_INT2FIX = 4'd8,
      OP_FIX2INT = 4'd9
   } op_type;

   typedef struct packed {
      logic [DATA_W-1:0] r;
      logic              ovf;
   } res_type;

   // Sideband that travels beside the divider.
   typedef struct packed {
      logic              valid;
      logic              is_div;
      logic              is_mul;
      logic              neg;
      logic              dz;
      logic              dov;
      logic              less;
      logic              equal;
      logic              greater;
      logic [DATA_W-1:0] r;
      logic              ovf;
   } side_type;

   // Clamp a wide signed value to the 32-bit range.
   function automatic res_type sat48(input logic signed [47:0] v);
      res_type res;
      res.ovf = 1'b0;
      if (v > 48'sd2147483647) begin
         res.r   = 32'h7FFF_FFFF;
         res.ovf = 1'b1;
      end else if (v < -48'sd2147483648) begin
         res.r   = 32'h8000_0000;
         res.ovf = 1'b1;
      end else begin
         res.r = v[DATA_W-1:0];
      end
      return res;
   endfunction

   // Apply a sign to a magnitude and clamp; big flags a magnitude beyond 33 bits.
   function automatic res_type sat_mag(input logic [DATA_W:0] mag, input logic big,
                                       input logic neg);
      res_type res;
      res.ovf = 1'b0;
      if (neg) begin
         if (big || mag > {1'b0, 32'h8000_0000}) begin
            res.r   = 32'h8000_0000;
            res.ovf = 1'b1;
         end else begin
            res.r = 32'(-mag);
         end
      end else begin
         if (big || mag > {1'b0, 32'h7FFF_FFFF}) begin
            res.r   = 32'h7FFF_FFFF;
            res.ovf = 1'b1;
         end else begin
            res.r = mag[DATA_W-1:0];
         end
      end
      return res;
   endfunction

endpackage

// ===== src/fpa_div.sv =====
// Pipelined restoring divider: one quotient bit per register stage.
// Depends on fpa_pkg for the data width and the stage count.
`timescale 1ns / 1ps
module fpa_div (
   input  logic                      clock,
   input  logic [fpa_pkg::DATA_W-1:0] rem_init,
   input  logic [fpa_pkg::DATA_W-1:0] num,
   input  logic [fpa_pkg::DATA_W-1:0] den,
   output logic [fpa_pkg::DATA_W-1:0] quo,
   output logic [fpa_pkg::DATA_W-1:0] rem,
   output logic [fpa_pkg::DATA_W-1:0] den_out
);
   import fpa_pkg::*;

   logic [DATA_W-1:0] rem_ff [DIV_STEPS];
   logic [DATA_W-1:0] num_ff [DIV_STEPS];
   logic [DATA_W-1:0] quo_ff [DIV_STEPS];
   logic [DATA_W-1:0] den_ff [DIV_STEPS];
   logic [DATA_W-1:0] rem_in [DIV_STEPS];
   logic [DATA_W-1:0] num_in [DIV_STEPS];
   logic [DATA_W-1:0] quo_in [DIV_STEPS];
   logic [DATA_W-1:0] den_in [DIV_STEPS];

   // Each stage shifts in the next numerator bit and subtracts when it fits.
   always_comb begin
      logic [DATA_W-1:0] r_prev, n_prev, q_prev, d_prev;
      logic [DATA_W:0]   t;
      for (int k = 0; k < DIV_STEPS; k++) begin
         if (k == 0) begin
            r_prev = rem_init;
            n_prev = num;
            q_prev = '0;
            d_prev = den;
         end else begin
            r_prev = rem_ff[k-1];
            n_prev = num_ff[k-1];
            q_prev = quo_ff[k-1];
            d_prev = den_ff[k-1];
         end
         t         = {r_prev, n_prev[DATA_W-1]};
         num_in[k] = n_prev << 1;
         den_in[k] = d_prev;
         if (t >= {1'b0, d_prev}) begin
            rem_in[k] = DATA_W'(t - {1'b0, d_prev});
            quo_in[k] = {q_prev[DATA_W-2:0], 1'b1};
         end else begin
            rem_in[k] = t[DATA_W-1:0];
            quo_in[k] = {q_prev[DATA_W-2:0], 1'b0};
         end
      end
   end

   // Stage registers carry payload only.
   always_ff @(posedge clock) begin
      for (int k = 0; k < DIV_STEPS; k++) begin
         rem_ff[k] <= rem_in[k];
         num_ff[k] <= num_in[k];
         quo_ff[k] <= quo_in[k];
         den_ff[k] <= den_in[k];
      end
   end

   assign quo     = quo_ff[DIV_STEPS-1];
   assign rem     = rem_ff[DIV_STEPS-1];
   assign den_out = den_ff[DIV_STEPS-1];

endmodule

// ===== src/fixed_point_alu_q8_core.sv =====
// Throughput: one request per cycle outside reset; the 32-stage divider and
// all other paths are fully pipelined and every operation takes the same latency.
// The receiver cannot stall; busy is high only while reset is asserted.
// Synchronous active-high reset clears all valid bits; payload is not reset.
// Depends on fpa_pkg and fpa_div.
`timescale 1ns / 1ps
module fixed_point_alu_q8_core #(
   parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [fpa_pkg::OP_W-1:0]         req_op,
   input  logic signed [fpa_pkg::DATA_W-1:0] req_operand_a,
   input  logic signed [fpa_pkg::DATA_W-1:0] req_operand_b,
   output logic                             rsp_valid,
   output logic signed [fpa_pkg::DATA_W-1:0] rsp_result,
   output logic                             rsp_less,
   output logic                             rsp_equal,
   output logic                             rsp_greater,
   output logic                             rsp_overflow,
   output logic                             rsp_divide_by_zero
);
   import fpa_pkg::*;

   localparam int CHAIN = DIV_STEPS - 2;

   // Input stage.
   logic                     s1_valid_ff;
   op_type                   s1_op_ff;
   logic signed [DATA_W-1:0] s1_a_ff, s1_b_ff;

   assign busy = reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start & ~busy;
      end
      s1_op_ff <= op_type'(req_op);
      s1_a_ff  <= req_operand_a;
      s1_b_ff  <= req_operand_b;
   end

   // Magnitudes, flags, the raw product and the results of all operations but multiply and divide.
   logic [DATA_W-1:0] mag_a, mag_b;
   side_type          sb2_in, sb2_ff;
   logic [2*DATA_W-1:0] prod2_ff;
   res_type           simple;

   always_comb begin
      mag_a = s1_a_ff[DATA_W-1] ? DATA_W'(-s1_a_ff) : DATA_W'(s1_a_ff);
      mag_b = s1_b_ff[DATA_W-1] ? DATA_W'(-s1_b_ff) : DATA_W'(s1_b_ff);
      simple = '0;
      unique case (s1_op_ff)
         OP_ADD:     simple = sat48(48'(s1_a_ff) + 48'(s1_b_ff));
         OP_SUB:     simple = sat48(48'(s1_a_ff) - 48'(s1_b_ff));
         OP_MIN:     simple.r = (s1_a_ff < s1_b_ff) ? s1_a_ff : s1_b_ff;
         OP_MAX:     simple.r = (s1_a_ff > s1_b_ff) ? s1_a_ff : s1_b_ff;
         OP_INC:     simple = sat48(48'(s1_a_ff) + 48'sd1);
         OP_DEC:     simple = sat48(48'(s1_a_ff) - 48'sd1);
         OP_INT2FIX: simple = sat48(48'(s1_a_ff) <<< FRAC_BITS);
         OP_FIX2INT: simple.r = DATA_W'((48'(s1_a_ff) + (s1_a_ff[DATA_W-1] ?
                        48'((1 << FRAC_BITS) - 1) : 48'sd0)) >>> FRAC_BITS);
         default:    simple = '0;
      endcase
      sb2_in.valid   = s1_valid_ff;
      sb2_in.is_div  = (s1_op_ff == OP_DIV);
      sb2_in.is_mul  = (s1_op_ff == OP_MUL);
      sb2_in.neg     = s1_a_ff[DATA_W-1] ^ s1_b_ff[DATA_W-1];
      sb2_in.dz      = (s1_b_ff == '0);
      sb2_in.dov     = (mag_a >> (DATA_W - FRAC_BITS)) >= mag_b;
      sb2_in.less    = s1_a_ff < s1_b_ff;
      sb2_in.equal   = s1_a_ff == s1_b_ff;
      sb2_in.greater = s1_a_ff > s1_b_ff;
      sb2_in.r       = simple.r;
      sb2_in.ovf     = simple.ovf;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sb2_ff.valid <= 1'b0;
      end else begin
         sb2_ff <= sb2_in;
      end
      prod2_ff <= mag_a * mag_b;
   end

   // Divider runs beside the sideband.
   logic [DATA_W-1:0] div_quo, div_rem, div_den;

   fpa_div u_div (
      .clock    (clock),
      .rem_init (DATA_W'(mag_a >> (DATA_W - FRAC_BITS))),
      .num      (DATA_W'(mag_a << FRAC_BITS)),
      .den      (mag_b),
      .quo      (div_quo),
      .rem      (div_rem),
      .den_out  (div_den)
   );

   // Product rounding, half away from zero on the magnitude.
   side_type          sb3_ff;
   logic [DATA_W:0]   mrnd3_ff;
   logic              mbig3_ff;
   logic [2*DATA_W-1:0] mr;

   assign mr = (prod2_ff + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;

   always_ff @(posedge clock) begin
      if (reset) begin
         sb3_ff.valid <= 1'b0;
      end else begin
         sb3_ff <= sb2_ff;
      end
      mrnd3_ff <= mr[DATA_W:0];
      mbig3_ff <= |mr[2*DATA_W-1:DATA_W+1];
   end

   // Signed, saturated product replaces the early result.
   side_type sb4_in;
   res_type  mul_res;

   always_comb begin
      mul_res = sat_mag(mrnd3_ff, mbig3_ff, sb3_ff.neg);
      sb4_in  = sb3_ff;
      if (sb3_ff.is_mul) begin
         sb4_in.r   = mul_res.r;
         sb4_in.ovf = mul_res.ovf;
      end
   end

   // Delay line that aligns the sideband with the rounded quotient.
   side_type chain_ff [CHAIN+1];

   always_ff @(posedge clock) begin
      for (int k = 0; k <= CHAIN; k++) begin
         if (reset) begin
            chain_ff[k].valid <= 1'b0;
         end else if (k == 0) begin
            chain_ff[k] <= sb4_in;
         end else begin
            chain_ff[k] <= chain_ff[k-1];
         end
      end
   end

   // Quotient rounding: round up when twice the remainder reaches the divisor.
   logic [DATA_W:0] rnd_ff, rnd_in;

   assign rnd_in = {1'b0, div_quo} +
                   (DATA_W+1)'({div_rem, 1'b0} >= {1'b0, div_den});

   always_ff @(posedge clock) begin
      rnd_ff <= rnd_in;
   end

   // Final selection into the response register.
   side_type fin;
   res_type  div_res, out_in;
   logic     dz_in;

   always_comb begin
      fin     = chain_ff[CHAIN];
      div_res = sat_mag(rnd_ff, fin.dov, fin.neg);
      dz_in   = 1'b0;
      out_in.r   = fin.r;
      out_in.ovf = fin.ovf;
      if (fin.is_div) begin
         if (fin.dz) begin
            out_in = '0;
            dz_in  = 1'b1;
         end else begin
            out_in = div_res;
         end
      end
   end

   logic                     rsp_valid_ff;
   logic [DATA_W-1:0]        rsp_result_ff;
   logic                     rsp_less_ff, rsp_equal_ff, rsp_greater_ff;
   logic                     rsp_overflow_ff, rsp_dz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= fin.valid;
      end
      rsp_result_ff   <= out_in.r;
      rsp_less_ff     <= fin.less;
      rsp_equal_ff    <= fin.equal;
      rsp_greater_ff  <= fin.greater;
      rsp_overflow_ff <= out_in.ovf;
      rsp_dz_ff       <= dz_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result         = rsp_result_ff;
   assign rsp_less           = rsp_less_ff;
   assign rsp_equal          = rsp_equal_ff;
   assign rsp_greater        = rsp_greater_ff;
   assign rsp_overflow       = rsp_overflow_ff;
   assign rsp_divide_by_zero = rsp_dz_ff;

endmodule

// ===== src/fpa_checker.sv =====
// Port-level checks for the fixed-point ALU, bound to the top level.
// Depends on fpa_pkg for the opcode names and the latency.
`timescale 1ns / 1ps
module fpa_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             start,
   input logic                             busy,
   input logic [fpa_pkg::OP_W-1:0]         req_op,
   input logic signed [fpa_pkg::DATA_W-1:0] req_operand_b,
   input logic                             rsp_valid,
   input logic signed [fpa_pkg::DATA_W-1:0] rsp_result,
   input logic                             rsp_less,
   input logic                             rsp_equal,
   input logic                             rsp_greater,
   input logic                             rsp_overflow,
   input logic                             rsp_divide_by_zero
);
   import fpa_pkg::*;

   logic acc;
   logic dz_req;

   assign acc    = start & ~busy;
   assign dz_req = acc && (req_op == OP_DIV) && (req_operand_b == '0);

   // Every response comes from a request accepted a fixed latency earlier.
   a_resp_origin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(acc, LATENCY))
      else $error("response without a matching request");

   // Exactly one comparison flag is set.
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot({rsp_less, rsp_equal, rsp_greater}))
      else $error("comparison flags not one-hot");

   // A division by zero gives zero without overflow.
   a_dz_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_divide_by_zero) |-> (rsp_result == '0 && !rsp_overflow))
      else $error("divide by zero result wrong");

   // A zero divisor request reports divide by zero.
   a_dz_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(dz_req, LATENCY)) |-> rsp_divide_by_zero)
      else $error("divide by zero flag missing");

endmodule

bind fixed_point_alu_q8_core fpa_checker u_fpa_checker (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .req_op             (req_op),
   .req_operand_b      (req_operand_b),
   .rsp_valid          (rsp_valid),
   .rsp_result         (rsp_result),
   .rsp_less           (rsp_less),
   .rsp_equal          (rsp_equal),
   .rsp_greater        (rsp_greater),
   .rsp_overflow       (rsp_overflow),
   .rsp_divide_by_zero (rsp_divide_by_zero)
);

// ===== sim/alu_checker.sv =====
// Watches the request and response channels of the fixed-point ALU, predicts each response.
// Depends on fpa_pkg; instantiated by tb_top beside the block.
`timescale 1ns / 1ps
module alu_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic                              busy,
   input  logic [fpa_pkg::OP_W-1:0]          req_op,
   input  logic signed [fpa_pkg::DATA_W-1:0] req_operand_a,
   input  logic signed [fpa_pkg::DATA_W-1:0] req_operand_b,
   input  logic                              rsp_valid,
   input  logic signed [fpa_pkg::DATA_W-1:0] rsp_result,
   input  logic                              rsp_less,
   input  logic                              rsp_equal,
   input  logic                              rsp_greater,
   input  logic                              rsp_overflow,
   input  logic                              rsp_divide_by_zero,
   output int                                fail_count,
   output int                                pending_count
);
   import fpa_pkg::*;

   localparam int FB = FRAC_BITS_DF;

   typedef struct packed {
      logic [31:0] result;
      logic        less;
      logic        equal;
      logic        greater;
      logic        overflow;
      logic        dz;
   } alu_resp_type;

   alu_resp_type expected_resp_q[$];

   // Clamp an exact value to the 32-bit range.
   function automatic longint clamp32(input longint v, inout logic ovf);
      if (v > 64'sd2147483647) begin
         ovf = 1'b1;
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         ovf = 1'b1;
         return -64'sd2147483648;
      end
      return v;
   endfunction

   // Exact math on raw operands; MUL/DIV round halves away from zero, FIX2INT truncates.
   function automatic alu_resp_type compute_alu(input logic [3:0] op,
                                                input logic signed [31:0] ia,
                                                input logic signed [31:0] ib);
      longint a, b, r;
      longint unsigned ma, mb, mag, num;
      logic neg, ovf, dz;
      alu_resp_type res;
      a = ia;
      b = ib;
      r = 0;
      ovf = 1'b0;
      dz = 1'b0;
      neg = (a < 0) != (b < 0);
      ma = (a < 0) ? -a : a;
      mb = (b < 0) ? -b : b;
      case (op)
         OP_ADD: r = clamp32(a + b, ovf);
         OP_SUB: r = clamp32(a - b, ovf);
         OP_MUL: begin
            mag = (ma * mb + (64'd1 << (FB - 1))) >> FB;
            r = clamp32(neg ? -longint'(mag) : longint'(mag), ovf);
         end
         OP_DIV: begin
            if (b == 0) begin
               dz = 1'b1;
            end else begin
               num = ma << FB;
               mag = (2 * num + mb) / (2 * mb);
               r = clamp32(neg ? -longint'(mag) : longint'(mag), ovf);
            end
         end
         OP_MIN: r = (a < b) ? a : b;
         OP_MAX: r = (a > b) ? a : b;
         OP_INC: r = clamp32(a + 1, ovf);
         OP_DEC: r = clamp32(a - 1, ovf);
         OP_INT2FIX: r = clamp32(a * (64'sd1 <<< FB), ovf);
         OP_FIX2INT: r = a / (64'sd1 <<< FB);
         default: r = 0;
      endcase
      res.result = r[31:0];
      res.less = a < b;
      res.equal = a == b;
      res.greater = a > b;
      res.overflow = ovf;
      res.dz = dz;
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   assign pending_count = expected_resp_q.size();

   initial fail_count = 0;

   // Predict on accepted requests and compare each response with the oldest prediction.
   always @(posedge clock) begin
      alu_resp_type want;
      if (!reset && start && !busy)
         expected_resp_q.push_back(compute_alu(req_op, req_operand_a, req_operand_b));
      if (!reset && rsp_valid) begin
         if (expected_resp_q.size() == 0) begin
            report_mismatch("unexpected response", rsp_result, 32'd0);
         end else begin
            want = expected_resp_q.pop_front();
            if (rsp_result !== want.result)
               report_mismatch("result", rsp_result, want.result);
            if (rsp_less !== want.less)
               report_mismatch("less", rsp_less, want.less);
            if (rsp_equal !== want.equal)
               report_mismatch("equal", rsp_equal, want.equal);
            if (rsp_greater !== want.greater)
               report_mismatch("greater", rsp_greater, want.greater);
            if (rsp_overflow !== want.overflow)
               report_mismatch("overflow", rsp_overflow, want.overflow);
            if (rsp_divide_by_zero !== want.dz)
               report_mismatch("divide_by_zero", rsp_divide_by_zero, want.dz);
         end
      end
   end
endmodule

// ===== sim/tb_top.sv =====
// Top of the fixed-point ALU testbench: clock, reset, request stimulus and verdict.
// Depends on fpa_pkg, fixed_point_alu_q8_core and alu_checker.
`timescale 1ns / 1ps
module tb_top;
   import fpa_pkg::*;

   localparam int N_RANDOM = 1650;
   localparam int WATCHDOG_LIMIT = 2000;

   logic clock, reset, start, busy;
   logic [OP_W-1:0] req_op;
   logic signed [DATA_W-1:0] req_operand_a, req_operand_b;
   logic rsp_valid, rsp_less, rsp_equal, rsp_greater, rsp_overflow, rsp_divide_by_zero;
   logic signed [DATA_W-1:0] rsp_result;
   int fail_count, pending_count, idle_cycles;

   fixed_point_alu_q8_core DUT (.*);

   alu_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: count cycles in which neither a request nor a response is taken.
   initial idle_cycles = 0;
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Pick an operand with a bias toward bounds, small values and whole numbers.
   function automatic logic [31:0] pick_operand();
      case ($urandom_range(0, 7))
         0: return 32'h7FFF_FFFF - $urandom_range(0, 2);
         1: return 32'h8000_0000 + $urandom_range(0, 2);
         2: return 32'($signed($urandom_range(0, 1024)) - 512);
         3: return 32'($signed($urandom_range(0, 8)) - 4) << 8;
         4: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
         default: return $urandom;
      endcase
   endfunction

   // Issue one request and hold it until accepted; optionally idle first.
   task automatic send_request(input logic [3:0] op, input logic [31:0] a, input logic [31:0] b,
                               input bit allow_gap);
      int gap;
      if (allow_gap && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 10);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_op <= op;
      req_operand_a <= a;
      req_operand_b <= b;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   initial begin
      logic [3:0] op;
      logic [31:0] a, b;
      int wait_cycles;
      start = 1'b0;
      reset = 1'b1;
      req_op = '0;
      req_operand_a = '0;
      req_operand_b = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: bounds, every opcode, and the named corner cases.
      send_request(OP_ADD, 32'h7FFF_FFFF, 32'h0000_0001, 0);
      send_request(OP_SUB, 32'h8000_0000, 32'h0000_0001, 0);
      send_request(OP_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
      send_request(OP_MUL, 32'h8000_0000, 32'h8000_0000, 0);
      send_request(OP_MUL, 32'h0000_0080, 32'h0000_0001, 0);
      send_request(OP_MUL, 32'hFFFF_FF80, 32'h0000_0001, 0);
      send_request(OP_DIV, 32'h0000_0100, 32'h0000_0000, 0);
      send_request(OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF, 0);
      send_request(OP_DIV, 32'h0000_0001, 32'h0000_0200, 0);
      send_request(OP_DIV, 32'hFFFF_FFFF, 32'h0000_0200, 0);
      send_request(OP_MIN, 32'h1234_5678, 32'h1234_5678, 0);
      send_request(OP_MAX, 32'h8000_0000, 32'h7FFF_FFFF, 0);
      send_request(OP_INC, 32'h7FFF_FFFF, 32'h0000_0000, 0);
      send_request(OP_DEC, 32'h8000_0000, 32'h8000_0000, 0);
      send_request(OP_INT2FIX, 32'h0080_0000, 32'h0000_0005, 0);
      send_request(OP_INT2FIX, 32'hFF7F_FFFF, 32'h0000_0005, 0);
      send_request(OP_FIX2INT, 32'hFFFF_FE01, 32'h0000_0000, 0);
      send_request(OP_FIX2INT, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0);
      send_request(4'd10, 32'h0000_0005, 32'h0000_0003, 0);
      send_request(4'd15, 32'hFFFF_FFFF, 32'h0000_0003, 0);

      // Random requests; the final stretch runs with no gaps.
      for (int i = 0; i < N_RANDOM; i++) begin
         op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                           : 4'($urandom_range(0, 9));
         a = pick_operand();
         b = ($urandom_range(0, 15) == 0) ? 32'd0 : pick_operand();
         if ($urandom_range(0, 15) == 0) b = a;
         send_request(op, a, b, i < N_RANDOM - 200);
      end
      start <= 1'b0;

      // Drain: wait for all responses, then the pipeline latency.
      wait_cycles = 0;
      while (pending_count != 0 && wait_cycles < 10 * LATENCY) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (LATENCY + 5) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end
endmodule
